[rtl/sau_pkg.sv]
// sau_pkg: shared types and constants for the stack arithmetic unit
package sau_pkg;

  // stack geometry and output limit
  localparam int STACK_DEPTH = 64;
  localparam int MAX_RESULTS = 64;
  localparam int AW          = $clog2(STACK_DEPTH);
  localparam int CW          = $clog2(STACK_DEPTH + 1);
  localparam int DW          = 32;

  // instruction codes
  localparam logic [2:0] F_PUSH  = 3'd0;
  localparam logic [2:0] F_ADD   = 3'd1;
  localparam logic [2:0] F_MUL   = 3'd2;
  localparam logic [2:0] F_PRINT = 3'd3;
  localparam logic [2:0] F_CLEAR = 3'd4;

  // result status codes
  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_BAD = 2'd1;
  localparam logic [1:0] ST_OVF = 2'd2;

  // request payload
  typedef struct packed {
    logic [2:0]          func;
    logic signed [31:0]  operand;
  } req_t;

  // result payload
  typedef struct packed {
    logic [1:0]          status;
    logic                has_value;
    logic signed [31:0]  stack_value;
    logic                last;
  } rsp_t;

endpackage

[rtl/sau_stack_ram.sv]
// sau_stack_ram: simple dual-port stack memory with registered read data
module sau_stack_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered, holds data between reads
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/stack_arith_unit_core.sv]
// stack_arith_unit_core: stack machine top level with control sequencer
// Executes one instruction per request on a 64-entry stack of 32-bit words held in a
// synchronous RAM. A request is taken only while the sequencer is idle; the result
// register lets it take the next request while the previous result still waits.
// Push, clear and rejected instructions go through the emit state to the result. Add and
// multiply with count N walk the top N entries through the single RAM read port,
// one entry per cycle into a registered accumulator, then write back the result. Print
// moves each value by a RAM read, then a result load, and waits while the result
// side stalls. Up to 64 results per print.
module stack_arith_unit_core (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  sau_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output sau_pkg::rsp_t rsp
);
  import sau_pkg::*;

  // sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EMIT  = 3'd1;
  localparam logic [2:0] S_RED   = 3'd2;
  localparam logic [2:0] S_WB    = 3'd3;
  localparam logic [2:0] S_PRD   = 3'd4;
  localparam logic [2:0] S_PWAIT = 3'd5;

  logic [2:0]    state;
  logic [CW-1:0] cnt;
  logic [1:0]    res_status;
  logic [AW-1:0] rd_addr;
  logic [CW-1:0] rd_left;
  logic [CW-1:0] dat_left;
  logic [CW-1:0] red_n;
  logic          pend;
  logic          first;
  logic          is_mul;
  logic          prn_up;
  logic [DW-1:0] acc;

  logic          out_free;
  logic          rsp_load;
  logic          op_pos;
  logic [30:0]   op_mag;
  logic [30:0]   cnt_ext;
  logic          red_ok;
  logic          prn_top;
  logic [CW-1:0] top_idx;
  logic [AW-1:0] top_addr;
  logic [CW-1:0] wb_idx;
  logic [DW-1:0] red_val;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [DW-1:0] ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [DW-1:0] ram_rdata;

  // limit a print sequence to the result budget
  function automatic logic [CW-1:0] clamp_len(input logic [CW-1:0] len);
    if (32'(len) > 32'(MAX_RESULTS)) begin
      return CW'(MAX_RESULTS);
    end
    return len;
  endfunction

  // handshake and decode
  assign out_free  = !rsp_valid || !rsp_stall;
  assign rsp_load  = (state == S_EMIT || state == S_PWAIT) && out_free;
  assign req_stall = (state != S_IDLE);
  assign op_pos    = !req.operand[31];
  assign op_mag    = req.operand[30:0];
  assign cnt_ext   = 31'(cnt);
  assign red_ok    = op_pos && (op_mag >= 31'd2) && (op_mag <= cnt_ext);
  assign prn_top   = op_pos && (op_mag >= 31'd1) && (op_mag <= cnt_ext);
  assign top_idx   = cnt - CW'(1);
  assign top_addr  = top_idx[AW-1:0];
  assign wb_idx    = cnt - red_n;

  // reduction step, one multiply or add per cycle
  assign red_val = is_mul ? (acc * ram_rdata) : (acc + ram_rdata);

  // memory port control
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = rd_addr;
    if (state == S_IDLE && req_valid && req.func == F_PUSH &&
        cnt != CW'(STACK_DEPTH)) begin
      ram_we    = 1'b1;
      ram_waddr = cnt[AW-1:0];
      ram_wdata = $unsigned(req.operand);
    end else if (state == S_WB) begin
      ram_we    = 1'b1;
      ram_waddr = wb_idx[AW-1:0];
      ram_wdata = acc;
    end
    if ((state == S_RED && rd_left != '0) || state == S_PRD) begin
      ram_re = 1'b1;
    end
  end

  sau_stack_ram #(
    .DEPTH(STACK_DEPTH),
    .WIDTH(DW)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      rsp_valid <= 1'b0;
      pend      <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall && !rsp_load) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            unique case (req.func)
              F_PUSH: begin
                if (cnt == CW'(STACK_DEPTH)) begin
                  res_status <= ST_OVF;
                end else begin
                  cnt        <= cnt + CW'(1);
                  res_status <= ST_OK;
                end
                state <= S_EMIT;
              end
              F_ADD, F_MUL: begin
                if (red_ok) begin
                  is_mul   <= (req.func == F_MUL);
                  red_n    <= op_mag[CW-1:0];
                  rd_addr  <= top_addr;
                  rd_left  <= op_mag[CW-1:0];
                  dat_left <= op_mag[CW-1:0];
                  first    <= 1'b1;
                  pend     <= 1'b0;
                  state    <= S_RED;
                end else begin
                  res_status <= ST_BAD;
                  state      <= S_EMIT;
                end
              end
              F_PRINT: begin
                if (cnt == '0) begin
                  res_status <= ST_OK;
                  state      <= S_EMIT;
                end else if (prn_top) begin
                  rd_addr <= top_addr;
                  prn_up  <= 1'b0;
                  rd_left <= clamp_len(op_mag[CW-1:0]);
                  state   <= S_PRD;
                end else begin
                  rd_addr <= '0;
                  prn_up  <= 1'b1;
                  rd_left <= clamp_len(cnt);
                  state   <= S_PRD;
                end
              end
              F_CLEAR: begin
                cnt        <= '0;
                res_status <= ST_OK;
                state      <= S_EMIT;
              end
              default: begin
                res_status <= ST_BAD;
                state      <= S_EMIT;
              end
            endcase
          end
        end
        S_EMIT: begin
          if (out_free) begin
            rsp_valid <= 1'b1;
            rsp       <= '{status: res_status, has_value: 1'b0,
                           stack_value: '0, last: 1'b1};
            state     <= S_IDLE;
          end
        end
        S_RED: begin
          // issue reads from the top down, fold the data in the cycle after each read
          pend <= (rd_left != '0);
          if (rd_left != '0) begin
            rd_addr <= rd_addr - AW'(1);
            rd_left <= rd_left - CW'(1);
          end
          if (pend) begin
            acc      <= first ? ram_rdata : red_val;
            first    <= 1'b0;
            dat_left <= dat_left - CW'(1);
            if (dat_left == CW'(1)) begin
              state <= S_WB;
            end
          end
        end
        S_WB: begin
          cnt        <= cnt - red_n + CW'(1);
          res_status <= ST_OK;
          state      <= S_EMIT;
        end
        S_PRD: begin
          rd_addr <= prn_up ? (rd_addr + AW'(1)) : (rd_addr - AW'(1));
          state   <= S_PWAIT;
        end
        S_PWAIT: begin
          if (out_free) begin
            rsp_valid <= 1'b1;
            rsp       <= '{status: ST_OK, has_value: 1'b1,
                           stack_value: $signed(ram_rdata),
                           last: (rd_left == CW'(1))};
            rd_left   <= rd_left - CW'(1);
            state     <= (rd_left == CW'(1)) ? S_IDLE : S_PRD;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // stack fill never passes the depth
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(STACK_DEPTH))
    else $error("stack count beyond depth");

  // a push onto a non-full stack grows it by one
  a_push_grow: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && req_valid && req.func == F_PUSH &&
     cnt != CW'(STACK_DEPTH)) |=> cnt == $past(cnt) + CW'(1))
    else $error("push did not grow the stack");

  // writeback of a reduction shrinks the stack by count minus one
  a_wb_shrink: assert property (@(posedge clk) disable iff (rst)
    (state == S_WB) |=> cnt == $past(cnt) - $past(red_n) + CW'(1))
    else $error("reduction writeback left a wrong count");

  // a reduction in progress always has data left to fold
  a_red_left: assert property (@(posedge clk) disable iff (rst)
    (state == S_RED) |-> dat_left != '0)
    else $error("reduction ran out of data");

endmodule

[bench/tb_stack_arith_unit_core.sv]
// tb_stack_arith_unit_core: self-checking bench for the stack arithmetic unit core
`timescale 1ns / 100ps

module tb_stack_arith_unit_core;
  import sau_pkg::*;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int ITEMS_TOTAL  = 410;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 200;
  localparam int MAX_REPORTS  = 10;

  // receiver stall behaviors
  typedef enum int {RX_FREE, RX_SPARSE, RX_PERIODIC, RX_HEAVY} stall_mode_e;

  logic clk;
  logic rst;
  logic req_valid;
  logic req_stall;
  req_t req;
  logic rsp_valid;
  logic rsp_stall;
  rsp_t rsp;

  // shadow stack and the results still owed by the block
  logic [DW-1:0] stk_mem [STACK_DEPTH];
  int            stk_count = 0;
  rsp_t          pending_rsp [$];

  int mismatch_count = 0;
  int items_sent     = 0;
  int burst_left     = 0;
  int cycle_count    = 0;
  bit no_gaps        = 1'b0;
  bit hold_req       = 1'b0;

  stack_arith_unit_core dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // append one expected result to the tail of the owed list
  function automatic void owe_rsp(input rsp_t r);
    pending_rsp.insert(pending_rsp.size(), r);
  endfunction

  // run one instruction on the shadow stack and queue what it should emit
  function automatic void exec_instr(input logic [2:0] f, input logic [DW-1:0] v);
    rsp_t          r;
    longint        n;
    logic [DW-1:0] acc;
    int            total;
    bit            all_bottom;
    n = $signed(v);
    r = '0;
    r.status = ST_OK;
    r.last = 1'b1;
    if (f == F_PRINT) begin
      // empty stack gives a single marker
      if (stk_count == 0) begin
        owe_rsp(r);
        return;
      end
      // out-of-range count dumps the whole stack bottom first
      all_bottom = (n < 1 || n > stk_count);
      total = all_bottom ? stk_count : int'(n);
      if (total > MAX_RESULTS) total = MAX_RESULTS;
      for (int i = 0; i < total; i++) begin
        r.has_value = 1'b1;
        r.stack_value = all_bottom ? stk_mem[i] : stk_mem[stk_count-1-i];
        r.last = (i == total - 1);
        owe_rsp(r);
      end
      return;
    end
    case (f)
      F_PUSH: begin
        if (stk_count >= STACK_DEPTH) begin
          r.status = ST_OVF;
        end else begin
          stk_mem[stk_count] = v;
          stk_count++;
        end
      end
      F_ADD, F_MUL: begin
        if (n < 2 || n > stk_count) begin
          r.status = ST_BAD;
        end else begin
          // fold top n entries, wrapping at 32 bits
          acc = stk_mem[stk_count-1];
          for (int i = 1; i < n; i++) begin
            acc = (f == F_MUL) ? acc * stk_mem[stk_count-1-i] : acc + stk_mem[stk_count-1-i];
          end
          stk_count -= int'(n) - 1;
          stk_mem[stk_count-1] = acc;
        end
      end
      F_CLEAR: stk_count = 0;
      default: r.status = ST_BAD;
    endcase
    owe_rsp(r);
  endfunction

  function automatic void report_mismatch(input string what, input rsp_t want,
                                          input rsp_t got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $display("mismatch (%s) at %0t: status/has_value/value/last want %0d/%0b/%h/%0b",
               what, $realtime, want.status, want.has_value, want.stack_value, want.last);
      $display("  got %0d/%0b/%h/%0b", got.status, got.has_value, got.stack_value, got.last);
    end
  endfunction

  // random mix of wide, small, negative and corner values
  function automatic logic [DW-1:0] rand_word();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 15);
      1: return -$urandom_range(1, 16);
      2: begin
        case ($urandom_range(0, 3))
          0: return 32'h7fff_ffff;
          1: return 32'h8000_0000;
          2: return 32'hffff_ffff;
          default: return 32'h0000_0000;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  // operand count: mostly in range, sometimes off either end
  function automatic logic [DW-1:0] pick_count(input bit printing);
    int lo;
    lo = printing ? 1 : 2;
    if (stk_count >= lo && $urandom_range(0, 9) < 7) return $urandom_range(lo, stk_count);
    case ($urandom_range(0, 4))
      0: return 0;
      1: return 1;
      2: return stk_count + 1;
      3: return $urandom;
      default: return -$urandom_range(1, 3);
    endcase
  endfunction

  // sender bursts with random gaps in between
  task automatic pace();
    int gap;
    if (!no_gaps) begin
      if (burst_left == 0) begin
        gap = $urandom_range(0, 6);
        if (gap > 0) begin
          req_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        burst_left = $urandom_range(1, 24);
      end
      burst_left--;
    end
  endtask

  // offer one request and hold it until taken
  task automatic send_req(input logic [2:0] f, input logic [DW-1:0] v);
    pace();
    req_valid <= 1'b1;
    req <= '{func: f, operand: v};
    do @(posedge clk); while (req_stall);
    exec_instr(f, v);
    items_sent++;
  endtask

  task automatic test_empty_stack();
    send_req(F_PRINT, 32'd0);
    send_req(F_ADD, 32'd2);
    send_req(F_CLEAR, 32'hffff_ffff);
  endtask

  task automatic test_print_order();
    send_req(F_PUSH, 32'h7fff_ffff);
    send_req(F_PUSH, 32'h8000_0000);
    send_req(F_PUSH, 32'hffff_ffff);
    send_req(F_PUSH, 32'h0000_0000);
    send_req(F_PUSH, 32'd3);
    send_req(F_PRINT, 32'd0);
    send_req(F_PRINT, 32'd2);
    send_req(F_PRINT, 32'hffff_ffff);
    send_req(F_PRINT, 32'd6);
    send_req(F_PRINT, 32'h7fff_ffff);
  endtask

  task automatic test_count_errors();
    send_req(F_ADD, 32'd1);
    send_req(F_ADD, 32'd0);
    send_req(F_MUL, 32'h8000_0000);
    send_req(F_ADD, 32'd6);
  endtask

  task automatic test_reductions();
    send_req(F_MUL, 32'd2);
    send_req(F_ADD, 32'd4);
    send_req(F_PUSH, 32'hffff_fffe);
    send_req(F_MUL, 32'd2);
    send_req(F_PRINT, 32'd1);
  endtask

  task automatic test_unknown_func();
    send_req(3'd5, 32'hffff_ffff);
    send_req(3'd6, 32'd2);
    send_req(3'd7, 32'h8000_0000);
  endtask

  task automatic test_clear();
    send_req(F_CLEAR, 32'd0);
    send_req(F_PRINT, 32'd1);
  endtask

  // receiver holds off at the start of a run of pushes that overruns the stack
  task automatic test_overflow_backpressure();
    hold_req = 1'b1;
    no_gaps = 1'b1;
    send_req(F_CLEAR, 32'd0);
    repeat (STACK_DEPTH + 3) send_req(F_PUSH, $urandom);
    no_gaps = 1'b0;
    send_req(F_PRINT, 32'd0);
    send_req(F_PRINT, STACK_DEPTH);
    send_req(F_ADD, STACK_DEPTH + 1);
    send_req(F_MUL, STACK_DEPTH);
    send_req(F_PRINT, 32'd1);
  endtask

  // short well-formed programs with some noise mixed in
  task automatic test_random_mix();
    int kind;
    while (items_sent < ITEMS_TOTAL) begin
      kind = $urandom_range(0, 99);
      no_gaps = ($urandom_range(0, 9) == 0);
      // keep the stack shallow most of the time
      if (stk_count > 24 && kind >= 11) kind = 50;
      if (kind < 6) begin
        send_req(F_CLEAR, rand_word());
      end else if (kind < 10) begin
        send_req(3'($urandom_range(5, 7)), $urandom);
      end else if (kind < 11) begin
        while (stk_count < STACK_DEPTH) send_req(F_PUSH, rand_word());
        repeat ($urandom_range(1, 2)) send_req(F_PUSH, $urandom);
      end else if (kind < 45) begin
        repeat ($urandom_range(1, 6)) send_req(F_PUSH, rand_word());
      end else if (kind < 70) begin
        send_req($urandom_range(0, 1) ? F_ADD : F_MUL, pick_count(1'b0));
      end else if (kind < 90) begin
        send_req(F_PRINT, pick_count(1'b1));
      end else begin
        send_req(3'($urandom), $urandom);
      end
    end
    no_gaps = 1'b0;
  endtask

  // result checker
  always @(posedge clk) begin : rsp_check
    rsp_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (pending_rsp.size() == 0) begin
        want = '0;
        report_mismatch("nothing expected", want, rsp);
      end else begin
        want = pending_rsp.pop_front();
        if (rsp.status !== want.status || rsp.has_value !== want.has_value ||
            rsp.stack_value !== want.stack_value || rsp.last !== want.last)
          report_mismatch("field", want, rsp);
      end
    end
  end

  // receiver stall pattern, with a long hold-off on request
  initial begin : rx_stall_gen
    stall_mode_e mode;
    int          span;
    int          phase;
    int          hold_left;
    bit          hold_taken;
    mode = RX_FREE;
    span = 0;
    phase = 0;
    hold_left = 0;
    hold_taken = 1'b0;
    rsp_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_stall <= 1'b1;
      end else begin
        if (span == 0) begin
          mode = stall_mode_e'($urandom_range(0, 3));
          span = $urandom_range(20, 200);
        end
        span--;
        phase++;
        case (mode)
          RX_FREE:     rsp_stall <= 1'b0;
          RX_SPARSE:   rsp_stall <= ($urandom_range(0, 3) == 0);
          RX_PERIODIC: rsp_stall <= (phase % 5 >= 3);
          default:     rsp_stall <= ($urandom_range(0, 9) < 7);
        endcase
      end
    end
  end

  // run-away guard
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_stack();
    test_print_order();
    test_count_errors();
    test_reductions();
    test_unknown_func();
    test_clear();
    test_overflow_backpressure();
    test_random_mix();
    req_valid <= 1'b0;

    // wait out the last results, then a little longer
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
